// ===== src/lfr_pkg.sv =====
`default_nettype none
package lfr_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int FRAME_W    = 6;
  localparam int FRAME_SPAN = 2 ** FRAME_W;
  // list never holds more entries than there are distinct frame numbers
  localparam int CAPACITY   = (NUM_FRAMES < FRAME_SPAN) ? NUM_FRAMES : FRAME_SPAN;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int OCC_W      = $clog2(CAPACITY + 1);
  localparam int STATUS_W   = 2;

  localparam logic ACT_REFERENCE = 1'b0;
  localparam logic ACT_EVICT     = 1'b1;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [OCC_W-1:0]   occ_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_REF_DONE = 2'd0,
    STAT_EVICTED  = 2'd1,
    STAT_EMPTY    = 2'd2
  } status_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   ref_en;
    frame_t frame;
  } lfr_ctl_t;

endpackage
`default_nettype wire

// ===== src/lfr_if.sv =====
`default_nettype none
interface lfr_in_if;
  logic            valid;
  logic            ready;
  logic            action;
  lfr_pkg::frame_t frame_number;

  modport source (output valid, output action, output frame_number, input ready);
  modport sink (input valid, input action, input frame_number, output ready);
endinterface

interface lfr_out_if;
  logic             valid;
  logic             ready;
  lfr_pkg::frame_t  victim_frame;
  lfr_pkg::status_t status;

  modport source (output valid, output victim_frame, output status, input ready);
  modport sink (input valid, input victim_frame, input status, output ready);
endinterface
`default_nettype wire

// ===== src/lru_frame_replacement.sv =====
`default_nettype none
// lru_frame_replacement: exact lru recency list over physical frame numbers
//
// req channel (sink): one word per request, action selects reference (0) or
// evict (1); frame_number is used by a reference only.
// rsp channel (source): exactly one word per request, in request order:
// status 0 reference done, 1 frame evicted (victim_frame valid), 2 evict on
// an empty list. victim_frame is 0 unless a frame was evicted.
//
// latency: the response appears the cycle after the request is accepted.
// throughput: one request per cycle unless stalled; the whole list
// updates through a row of cells, each matching its entry against the
// frame and taking its front neighbor's entry when no hit lies ahead.
//
// reset (rst, synchronous) empties the list and drops any pending response.
// the list contents themselves are not cleared; occupancy marks which cells
// hold live entries.
//
// when rsp stalls, the response holds in the output register and req is
// held off until that word is taken.
module lru_frame_replacement (
  input  wire logic  clk,
  input  wire logic  rst,
  lfr_in_if.sink     req,
  lfr_out_if.source  rsp
);

  localparam int CAP = lfr_pkg::CAPACITY;

  lfr_pkg::occ_t     occupancy;
  lfr_pkg::occ_t     occupancy_next;
  lfr_pkg::occ_t     occ_less_one;
  logic              out_valid;
  lfr_pkg::frame_t   out_victim;
  lfr_pkg::status_t  out_status;

  logic              accept;
  lfr_pkg::lfr_ctl_t ctl;
  lfr_pkg::frame_t   entry [CAP];
  logic [CAP:0]      hit;
  logic              found;
  lfr_pkg::frame_t   tail_entry;

  // request taken whenever the output register is free or being drained
  assign req.ready = !rst && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign ctl.ref_en = accept && (req.action == lfr_pkg::ACT_REFERENCE);
  assign ctl.frame  = req.frame_number;

  // cell chain: cell 0 is the most recent end and takes the new frame
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAP; i++) begin : gen_cell
    lfr_pkg::frame_t prev;
    logic            occupied;

    if (i == 0) begin : gen_head
      assign prev = req.frame_number;
    end else begin : gen_body
      assign prev = entry[i-1];
    end

    assign occupied = occupancy > lfr_pkg::occ_t'(i);

    lfr_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .prev_entry (prev),
      .occupied   (occupied),
      .hit_in     (hit[i]),
      .entry      (entry[i]),
      .hit_out    (hit[i+1])
    );
  end

  assign found = hit[CAP];

  // least recent live entry sits just below the occupancy count
  assign occ_less_one = lfr_pkg::occ_t'(occupancy - lfr_pkg::occ_t'(1));
  assign tail_entry   = entry[occ_less_one[lfr_pkg::IDX_W-1:0]];

  always_comb begin
    occupancy_next = occupancy;
    if (accept) begin
      if (req.action == lfr_pkg::ACT_EVICT) begin
        if (occupancy != '0) begin
          occupancy_next = occ_less_one;
        end
      end else if (!found && (occupancy != lfr_pkg::occ_t'(CAP))) begin
        // new frame; at capacity the tail simply drops off the chain
        occupancy_next = lfr_pkg::occ_t'(occupancy + lfr_pkg::occ_t'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      occupancy <= occupancy_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (req.action == lfr_pkg::ACT_REFERENCE) begin
        out_victim <= '0;
        out_status <= lfr_pkg::STAT_REF_DONE;
      end else if (occupancy == '0) begin
        out_victim <= '0;
        out_status <= lfr_pkg::STAT_EMPTY;
      end else begin
        out_victim <= tail_entry;
        out_status <= lfr_pkg::STAT_EVICTED;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.victim_frame = out_victim;
  assign rsp.status       = out_status;

endmodule
`default_nettype wire

// ===== src/lfr_cell.sv =====
`default_nettype none
module lfr_cell (
  input  wire logic              clk,
  input  wire lfr_pkg::lfr_ctl_t ctl,
  input  wire lfr_pkg::frame_t   prev_entry,
  input  wire logic              occupied,
  input  wire logic              hit_in,
  output lfr_pkg::frame_t        entry,
  output logic                   hit_out
);

  // a hit here or anywhere closer to the front stops the shift behind it
  assign hit_out = hit_in || (occupied && (entry == ctl.frame));

  always_ff @(posedge clk) begin
    if (ctl.ref_en && !hit_in) begin
      entry <= prev_entry;
    end
  end

endmodule
`default_nettype wire

// ===== src/lfr_checker.sv =====
`default_nettype none
module lfr_checker (
  input  wire logic  clk,
  input  wire logic  rst,
  lfr_in_if.sink     req,
  lfr_out_if.source  rsp
);

  logic acc;
  logic acc_ref;
  logic acc_evict;

  assign acc       = req.valid && req.ready;
  assign acc_ref   = acc && (req.action == lfr_pkg::ACT_REFERENCE);
  assign acc_evict = acc && (req.action == lfr_pkg::ACT_EVICT);

  // a stalled response word stays up
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid)
    else $error("response dropped while stalled");

  // every accepted word gives a response in the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    acc |=> rsp.valid)
    else $error("no response after accepted request");

  a_ref_status: assert property (@(posedge clk) disable iff (rst)
    acc_ref |=> (rsp.status == lfr_pkg::STAT_REF_DONE) && (rsp.victim_frame == '0))
    else $error("reference response wrong");

  // an evict right behind a reference always finds a frame
  a_evict_after_ref: assert property (@(posedge clk) disable iff (rst)
    acc_ref ##1 acc_evict |=> rsp.status == lfr_pkg::STAT_EVICTED)
    else $error("evict after reference saw an empty list");

  a_empty_victim: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != lfr_pkg::STAT_EVICTED) |-> rsp.victim_frame == '0)
    else $error("victim frame set without eviction");

endmodule

bind lru_frame_replacement lfr_checker u_lfr_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);
`default_nettype wire
